FILE: hw/rtl/tun_pkg.sv
// ----------------------------------------------------------------------------
// tun_pkg
// shared constants for the triangle unit normal pipeline
// ----------------------------------------------------------------------------
package tun_pkg;

  localparam int IN_WIDTH            = 16;  // width of a coordinate port
  localparam int NORMAL_WIDTH        = 16;  // width of a normal component port
  localparam int COORD_WIDTH_DEF     = 16;
  localparam int NORMAL_FRAC_BITS_DEF = 14;

endpackage

FILE: hw/rtl/triangle_unit_normal.sv
// ----------------------------------------------------------------------------
// triangle_unit_normal
// unit face normal of a triangle, fully pipelined, one triangle per cycle
// ----------------------------------------------------------------------------
// usage
//   input channel: drive the nine in_* vertex coordinates and pulse start;
//   a transfer happens on every rising edge with start high and busy low.
//   busy is always low, so a new triangle may enter every cycle.
//   result channel: out_valid marks a result for exactly one cycle, carrying
//   out_normal_x/y/z (component scaled by 2^NORMAL_FRAC_BITS, rounded to
//   nearest, ties away from zero) and out_degenerate (zero cross product,
//   normal forced to zero). the receiver cannot stall; results are in order.
//   pipeline from transfer to out_valid: edges, products, cross product,
//   partial squares, squares, length sum, then one stage per quotient bit of
//   the bit-serial square-root divide (NORMAL_FRAC_BITS + 2 stages), then the
//   rounding/output register.
//   throughput: one triangle per cycle, set by the fully unrolled pipeline.
//   reset: synchronous active-low rst_n clears every stage valid bit; data
//   registers hold garbage that is never shown.
// ----------------------------------------------------------------------------
module triangle_unit_normal
  import tun_pkg::*;
#(
  parameter int COORD_WIDTH      = COORD_WIDTH_DEF,
  parameter int NORMAL_FRAC_BITS = NORMAL_FRAC_BITS_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  output logic                       busy,
  input  logic signed [IN_WIDTH-1:0] in_first_x,
  input  logic signed [IN_WIDTH-1:0] in_first_y,
  input  logic signed [IN_WIDTH-1:0] in_first_z,
  input  logic signed [IN_WIDTH-1:0] in_second_x,
  input  logic signed [IN_WIDTH-1:0] in_second_y,
  input  logic signed [IN_WIDTH-1:0] in_second_z,
  input  logic signed [IN_WIDTH-1:0] in_third_x,
  input  logic signed [IN_WIDTH-1:0] in_third_y,
  input  logic signed [IN_WIDTH-1:0] in_third_z,
  output logic                       out_valid,
  output logic signed [NORMAL_WIDTH-1:0] out_normal_x,
  output logic signed [NORMAL_WIDTH-1:0] out_normal_y,
  output logic signed [NORMAL_WIDTH-1:0] out_normal_z,
  output logic                       out_degenerate
);

  // used coordinate bits, edge, product, cross and square widths
  localparam int UW  = (COORD_WIDTH < IN_WIDTH) ? COORD_WIDTH : IN_WIDTH;
  localparam int EW  = UW + 1;
  localparam int PW  = 2 * EW;
  localparam int CW  = PW + 1;
  localparam int QW  = 2 * CW;
  localparam int SW  = QW + 2;
  localparam int F   = NORMAL_FRAC_BITS;
  localparam int KW  = F + 2;             // bits of floor(2^(F+1)|c|/len)
  localparam int WW  = SW + 2 * KW + 1;   // remainder / partial product width
  localparam int LW  = (CW + 1) / 2;      // low half of a magnitude
  localparam int HW  = CW - LW;           // high half of a magnitude

  assign busy = 1'b0;

  // ---------------------------------------------------------------- stage 1
  // edges a = first - second, b = first - third
  logic [UW-1:0] f_c [3];
  logic [UW-1:0] s_c [3];
  logic [UW-1:0] t_c [3];
  logic signed [EW-1:0] ea_r [3];
  logic signed [EW-1:0] eb_r [3];
  logic s1_vld_r;

  always_comb begin
    f_c[0] = in_first_x[UW-1:0];  f_c[1] = in_first_y[UW-1:0];
    f_c[2] = in_first_z[UW-1:0];
    s_c[0] = in_second_x[UW-1:0]; s_c[1] = in_second_y[UW-1:0];
    s_c[2] = in_second_z[UW-1:0];
    t_c[0] = in_third_x[UW-1:0];  t_c[1] = in_third_y[UW-1:0];
    t_c[2] = in_third_z[UW-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else begin
      s1_vld_r <= start && !busy;
    end
    for (int i = 0; i < 3; i++) begin
      ea_r[i] <= $signed({f_c[i][UW-1], f_c[i]}) - $signed({s_c[i][UW-1], s_c[i]});
      eb_r[i] <= $signed({f_c[i][UW-1], f_c[i]}) - $signed({t_c[i][UW-1], t_c[i]});
    end
  end

  // ---------------------------------------------------------------- stage 2
  // the six cross-product terms
  logic signed [PW-1:0] pp_r [3];
  logic signed [PW-1:0] pq_r [3];
  logic s2_vld_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_vld_r <= 1'b0;
    end else begin
      s2_vld_r <= s1_vld_r;
    end
    pp_r[0] <= ea_r[1] * eb_r[2];
    pq_r[0] <= eb_r[1] * ea_r[2];
    pp_r[1] <= eb_r[0] * ea_r[2];
    pq_r[1] <= ea_r[0] * eb_r[2];
    pp_r[2] <= ea_r[0] * eb_r[1];
    pq_r[2] <= eb_r[0] * ea_r[1];
  end

  // ---------------------------------------------------------------- stage 3
  // cross product c = a x b
  logic signed [CW-1:0] cr_r [3];
  logic s3_vld_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_vld_r <= 1'b0;
    end else begin
      s3_vld_r <= s2_vld_r;
    end
    for (int i = 0; i < 3; i++) begin
      cr_r[i] <= $signed({pp_r[i][PW-1], pp_r[i]}) - $signed({pq_r[i][PW-1], pq_r[i]});
    end
  end

  // ---------------------------------------------------------------- stage 4
  // component magnitudes split in halves, partial squares, signs kept aside
  logic [CW-1:0]    mag_c [3];
  logic [2*HW-1:0]  phh_r [3];
  logic [HW+LW-1:0] phl_r [3];
  logic [2*LW-1:0]  pll_r [3];
  logic [2:0]       s4_neg_r;
  logic             s4_vld_r;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      mag_c[i] = cr_r[i][CW-1] ? CW'(-cr_r[i]) : CW'(cr_r[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s4_vld_r <= 1'b0;
    end else begin
      s4_vld_r <= s3_vld_r;
    end
    for (int i = 0; i < 3; i++) begin
      phh_r[i]    <= mag_c[i][CW-1:LW] * mag_c[i][CW-1:LW];
      phl_r[i]    <= mag_c[i][CW-1:LW] * mag_c[i][LW-1:0];
      pll_r[i]    <= mag_c[i][LW-1:0] * mag_c[i][LW-1:0];
      s4_neg_r[i] <= cr_r[i][CW-1];
    end
  end

  // ---------------------------------------------------------------- stage 5
  // squares: hh * 2^(2L) + 2 * hl * 2^L + ll
  logic [QW-1:0] sq_r [3];
  logic [2:0]    s5_neg_r;
  logic          s5_vld_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s5_vld_r <= 1'b0;
    end else begin
      s5_vld_r <= s4_vld_r;
    end
    s5_neg_r <= s4_neg_r;
    for (int i = 0; i < 3; i++) begin
      sq_r[i] <= (QW'(phh_r[i]) << (2 * LW)) + (QW'(phl_r[i]) << (LW + 1))
                 + QW'(pll_r[i]);
    end
  end

  // ---------------------------------------------------------------- stage 6
  // squared length S and targets T_i = c_i^2 * 2^(2F+2) seed the divider
  logic [WW-1:0] it_rem_r  [0:KW][3];
  logic [WW-1:0] it_prod_r [0:KW][3];
  logic [KW-1:0] it_k_r    [0:KW][3];
  logic [SW-1:0] it_sum_r  [0:KW];
  logic [2:0]    it_neg_r  [0:KW];
  logic          it_degen_r[0:KW];
  logic          it_vld_r  [0:KW];
  logic [SW-1:0] sum_c;

  assign sum_c = SW'(sq_r[0]) + SW'(sq_r[1]) + SW'(sq_r[2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      it_vld_r[0] <= 1'b0;
    end else begin
      it_vld_r[0] <= s5_vld_r;
    end
    it_sum_r[0]   <= sum_c;
    it_neg_r[0]   <= s5_neg_r;
    it_degen_r[0] <= (sum_c == '0);
    for (int i = 0; i < 3; i++) begin
      it_rem_r[0][i]  <= WW'(sq_r[i]) << (2 * F + 2);
      it_prod_r[0][i] <= '0;
      it_k_r[0][i]    <= '0;
    end
  end

  // ------------------------------------------------------- stages 7 .. 6+KW
  // one quotient bit per stage: largest k with k^2 * S <= T.
  // rem = T - k^2 S, prod = k S; trying bit b adds (2^(b+1) prod + 2^(2b) S)
  for (genvar g = 0; g < KW; g++) begin : g_iter
    localparam int B = KW - 1 - g;
    logic [WW-1:0] inc_c [3];
    logic [WW-1:0] sum_w;

    assign sum_w = WW'(it_sum_r[g]);

    always_comb begin
      for (int i = 0; i < 3; i++) begin
        inc_c[i] = (it_prod_r[g][i] << (B + 1)) + (sum_w << (2 * B));
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        it_vld_r[g+1] <= 1'b0;
      end else begin
        it_vld_r[g+1] <= it_vld_r[g];
      end
      it_sum_r[g+1]   <= it_sum_r[g];
      it_neg_r[g+1]   <= it_neg_r[g];
      it_degen_r[g+1] <= it_degen_r[g];
      for (int i = 0; i < 3; i++) begin
        if (inc_c[i] <= it_rem_r[g][i]) begin
          it_rem_r[g+1][i]  <= it_rem_r[g][i] - inc_c[i];
          it_prod_r[g+1][i] <= it_prod_r[g][i] + (sum_w << B);
          it_k_r[g+1][i]    <= it_k_r[g][i] | (KW'(1) << B);
        end else begin
          it_rem_r[g+1][i]  <= it_rem_r[g][i];
          it_prod_r[g+1][i] <= it_prod_r[g][i];
          it_k_r[g+1][i]    <= it_k_r[g][i];
        end
      end
    end
  end

  // ----------------------------------------------------------- output stage
  // m = (k + 1) / 2 rounds to nearest, then the sign goes back on
  logic [KW:0]             kp1_c [3];
  logic [NORMAL_WIDTH-1:0] m_c   [3];
  logic [NORMAL_WIDTH-1:0] nrm_c [3];
  logic                    out_valid_r;
  logic                    out_degen_r;
  logic [NORMAL_WIDTH-1:0] out_nrm_r [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      kp1_c[i] = {1'b0, it_k_r[KW][i]} + (KW+1)'(1);
      m_c[i]   = NORMAL_WIDTH'(kp1_c[i] >> 1);
      if (it_degen_r[KW]) begin
        nrm_c[i] = '0;
      end else if (it_neg_r[KW][i]) begin
        nrm_c[i] = -m_c[i];
      end else begin
        nrm_c[i] = m_c[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= it_vld_r[KW];
    end
    out_degen_r <= it_degen_r[KW];
    for (int i = 0; i < 3; i++) begin
      out_nrm_r[i] <= nrm_c[i];
    end
  end

  assign out_valid      = out_valid_r;
  assign out_degenerate = out_degen_r;
  assign out_normal_x   = $signed(out_nrm_r[0]);
  assign out_normal_y   = $signed(out_nrm_r[1]);
  assign out_normal_z   = $signed(out_nrm_r[2]);

  // ------------------------------------------------------------- assertions
  localparam logic [NORMAL_WIDTH-1:0] ONE_FIX = NORMAL_WIDTH'(1) << F;

  a_degen_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_degenerate |->
      out_nrm_r[0] == '0 && out_nrm_r[1] == '0 && out_nrm_r[2] == '0)
    else $error("degenerate result with nonzero normal");

  a_unit_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_degenerate |->
      (out_nrm_r[0][NORMAL_WIDTH-1] ? -out_nrm_r[0] : out_nrm_r[0]) <= ONE_FIX &&
      (out_nrm_r[1][NORMAL_WIDTH-1] ? -out_nrm_r[1] : out_nrm_r[1]) <= ONE_FIX &&
      (out_nrm_r[2][NORMAL_WIDTH-1] ? -out_nrm_r[2] : out_nrm_r[2]) <= ONE_FIX)
    else $error("normal component beyond unit");

  a_degen_cross: assert property (@(posedge clk) disable iff (!rst_n)
    s5_vld_r |=> it_degen_r[0] == ($past(sq_r[0]) == '0 && $past(sq_r[1]) == '0
                                    && $past(sq_r[2]) == '0))
    else $error("degenerate flag disagrees with cross product");

  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result strobe right after reset");

endmodule
